@@ design/periodic_timer_table_macros.svh @@
// assertion macros used by the port-level checker of the periodic timer table
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PTT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic timer table check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic timer table check failed");

`endif

@@ design/ptt_pkg.sv @@
// types and constants of the periodic timer table
`default_nettype none

package ptt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_FIRE      = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_REPLY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  timer_id;
        logic [31:0] new_interval;
        logic [31:0] raw_time;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic        ok;
        logic [3:0]  slot_out;
        logic [31:0] fired_interval;
        logic [31:0] elapsed;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_APPLY,
        ST_SCAN,
        ST_CLOSE
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE,
        CELL_WRITE,
        CELL_FLAGS
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     at_pos;
        logic     from_pos;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic armed;
        logic awaiting;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ design/ptt_cell.sv @@
// one cell of the age-ordered timer chain
`default_nettype none

module ptt_cell #(
    parameter int SLOT_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ptt_pkg::cell_ctl_t   ctl,
    input  wire ptt_pkg::cell_flags_t prev_flags,
    input  wire logic [SLOT_W-1:0]    prev_slot,
    input  wire logic [31:0]          prev_deadline,
    input  wire logic [31:0]          prev_period,
    input  wire ptt_pkg::cell_flags_t next_flags,
    input  wire logic [SLOT_W-1:0]    next_slot,
    input  wire logic [31:0]          next_deadline,
    input  wire logic [31:0]          next_period,
    input  wire ptt_pkg::cell_flags_t wr_flags,
    input  wire logic [SLOT_W-1:0]    wr_slot,
    input  wire logic [31:0]          wr_deadline,
    input  wire logic [31:0]          wr_period,
    output ptt_pkg::cell_flags_t      cur_flags,
    output logic [SLOT_W-1:0]         cur_slot,
    output logic [31:0]               cur_deadline,
    output logic [31:0]               cur_period
);

    ptt_pkg::cell_flags_t flags_reg, flags_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [31:0]          deadline_reg, deadline_next;
    logic [31:0]          period_reg, period_next;

    always_comb
    begin
        flags_next    = flags_reg;
        slot_next     = slot_reg;
        deadline_next = deadline_reg;
        period_next   = period_reg;
        unique case (ctl.op)
            ptt_pkg::CELL_HOLD:
            begin
            end
            ptt_pkg::CELL_INSERT:
            begin
                flags_next    = prev_flags;
                slot_next     = prev_slot;
                deadline_next = prev_deadline;
                period_next   = prev_period;
            end
            ptt_pkg::CELL_DELETE:
            begin
                if (ctl.from_pos)
                begin
                    flags_next    = next_flags;
                    slot_next     = next_slot;
                    deadline_next = next_deadline;
                    period_next   = next_period;
                end
            end
            ptt_pkg::CELL_ROTATE:
            begin
                flags_next    = next_flags;
                slot_next     = next_slot;
                deadline_next = next_deadline;
                period_next   = next_period;
            end
            ptt_pkg::CELL_WRITE:
            begin
                if (ctl.at_pos)
                begin
                    flags_next    = wr_flags;
                    slot_next     = wr_slot;
                    deadline_next = wr_deadline;
                    period_next   = wr_period;
                end
            end
            ptt_pkg::CELL_FLAGS:
            begin
                if (ctl.at_pos)
                begin
                    flags_next = wr_flags;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        deadline_reg <= deadline_next;
        period_reg   <= period_next;
    end

    assign cur_flags    = flags_reg;
    assign cur_slot     = slot_reg;
    assign cur_deadline = deadline_reg;
    assign cur_period   = period_reg;

endmodule

`default_nettype wire

@@ design/periodic_timer_table.sv @@
// top level of the periodic timer table: control, slot map and cell chain
`default_nettype none

// a table of SLOTS one-shot or periodic timers kept in a chain of cells ordered by
// age, newest in cell 0. add, remove and reply pass through accept, slot lookup
// across all cells and apply, waiting in apply only while the response side stalls.
// a tick with no replies owed rotates the chain one cell per cycle past the head
// cell, a step waiting while a finished result has not been taken. the head cell
// checks its deadline with a wraparound compare against the tick's elapsed time and
// emits a fired result when due, so firings come newest first; the closing result
// follows the full turn. one request is in flight at a time, but the request side
// is ready again while the last result sits in the output register. the user must
// write tick_origin through cfg_we/cfg_wdata only while idle; the block does not
// enforce it. there is no clearing pass after reset; cell valid flags clear at once
module periodic_timer_table #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_wdata,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ptt_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output ptt_pkg::rsp_t       rsp
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (SLOT_W > 4) ? SLOT_W : 4;

    // control state
    ptt_pkg::state_t state_reg, state_next;
    logic [31:0]     tick_origin_reg;
    logic [31:0]     dispatch_reg;
    logic [SLOTS-1:0] occ_reg;              // slot number in use, armed or awaiting reply
    logic [CNT_W-1:0] outstanding_reg;      // firings not yet answered
    logic             rsp_valid_reg;

    // current transaction and lookup results
    ptt_pkg::req_t    item_reg;
    logic [31:0]      now_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic             hit_reg;
    logic             hit_armed_reg;
    logic             hit_await_reg;
    logic [SLOT_W-1:0] free_reg;
    logic             full_reg;
    logic             blocked_reg;
    logic [SLOT_W-1:0] scan_cnt_reg;
    ptt_pkg::rsp_t    rsp_reg;

    // cell chain
    ptt_pkg::cell_ctl_t   cell_ctl [SLOTS];
    ptt_pkg::cell_flags_t cell_flags [SLOTS];
    logic [SLOT_W-1:0]    cell_slot [SLOTS];
    logic [31:0]          cell_deadline [SLOTS];
    logic [31:0]          cell_period [SLOTS];
    ptt_pkg::cell_flags_t prev_flags [SLOTS];
    logic [SLOT_W-1:0]    prev_slot [SLOTS];
    logic [31:0]          prev_deadline [SLOTS];
    logic [31:0]          prev_period [SLOTS];
    ptt_pkg::cell_flags_t next_flags [SLOTS];
    logic [SLOT_W-1:0]    next_slot [SLOTS];
    logic [31:0]          next_deadline [SLOTS];
    logic [31:0]          next_period [SLOTS];

    // lookup
    logic [SLOTS-1:0]  hit_vec;
    logic [SLOT_W-1:0] hit_pos;
    logic              hit_armed;
    logic              hit_await;
    logic [SLOT_W-1:0] free_slot;

    // per-cycle control
    logic                 out_free;
    logic                 accept;
    logic                 emit;
    ptt_pkg::rsp_t        rsp_next;
    ptt_pkg::cell_op_t    cell_op;
    ptt_pkg::cell_flags_t wr_flags;
    logic [SLOT_W-1:0]    wr_slot;
    logic [31:0]          wr_base;
    logic [31:0]          wr_deadline;
    ptt_pkg::cell_flags_t tail_flags;
    logic                 occ_set;
    logic                 occ_clr;
    logic                 out_inc;
    logic                 out_dec;
    logic                 disp_we;
    logic                 scan_step;

    // head of the chain during a tick
    logic [31:0] head_diff;
    logic        head_fire;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign accept   = req_valid && req_ready;

    // reply reloads count from the last tick, add from this transaction's time
    assign wr_base     = (item_reg.op == ptt_pkg::OP_REPLY) ? dispatch_reg : now_reg;
    assign wr_deadline = wr_base + item_reg.new_interval;

    assign head_diff = now_reg - cell_deadline[0];
    assign head_fire = cell_flags[0].valid && cell_flags[0].armed &&
                       !cell_flags[0].awaiting && !head_diff[31] &&
                       (32'(outstanding_reg) < ptt_pkg::MAX_FIRE);

    // find the cell that holds the named slot, and the lowest free slot number
    always_comb
    begin
        hit_pos   = '0;
        hit_armed = 1'b0;
        hit_await = 1'b0;
        free_slot = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            hit_vec[k] = cell_flags[k].valid &&
                         (CMP_W'(cell_slot[k]) == CMP_W'(item_reg.timer_id));
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            if (hit_vec[k])
            begin
                hit_pos   = hit_pos | SLOT_W'(k);
                hit_armed = hit_armed | cell_flags[k].armed;
                hit_await = hit_await | cell_flags[k].awaiting;
            end
        end
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (!occ_reg[k])
            begin
                free_slot = SLOT_W'(k);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ptt_pkg::ST_FIND;
                end
            end
            ptt_pkg::ST_FIND:
            begin
                if (item_reg.op == ptt_pkg::OP_TICK)
                begin
                    state_next = (outstanding_reg != '0) ? ptt_pkg::ST_CLOSE
                                                         : ptt_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = ptt_pkg::ST_APPLY;
                end
            end
            ptt_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ptt_pkg::ST_IDLE;
                end
            end
            ptt_pkg::ST_SCAN:
            begin
                if (out_free && scan_cnt_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ptt_pkg::ST_CLOSE;
                end
            end
            ptt_pkg::ST_CLOSE:
            begin
                if (out_free)
                begin
                    state_next = ptt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of each state
    always_comb
    begin
        req_ready  = 1'b0;
        emit       = 1'b0;
        rsp_next   = '0;
        cell_op    = ptt_pkg::CELL_HOLD;
        wr_flags   = '0;
        wr_slot    = free_reg;
        tail_flags = '0;
        occ_set    = 1'b0;
        occ_clr    = 1'b0;
        out_inc    = 1'b0;
        out_dec    = 1'b0;
        disp_we    = 1'b0;
        scan_step  = 1'b0;
        unique case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ptt_pkg::ST_FIND:
            begin
            end
            ptt_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    rsp_next.last     = 1'b1;
                    rsp_next.slot_out = item_reg.timer_id;
                    unique case (item_reg.op)
                        ptt_pkg::OP_ADD:
                        begin
                            rsp_next.kind     = ptt_pkg::KIND_ADD;
                            rsp_next.elapsed  = now_reg;
                            rsp_next.slot_out = '0;
                            if (item_reg.new_interval != '0 && !full_reg)
                            begin
                                // new timer enters at the newest end of the chain
                                rsp_next.ok       = 1'b1;
                                rsp_next.slot_out = 4'(free_reg);
                                cell_op           = ptt_pkg::CELL_INSERT;
                                wr_flags          = '{valid: 1'b1, armed: 1'b1,
                                                      awaiting: 1'b0};
                                occ_set           = 1'b1;
                            end
                        end
                        ptt_pkg::OP_REMOVE:
                        begin
                            rsp_next.kind = ptt_pkg::KIND_REMOVE;
                            if (hit_reg && hit_armed_reg)
                            begin
                                rsp_next.ok = 1'b1;
                                if (hit_await_reg)
                                begin
                                    // keep the slot until its reply frees it
                                    cell_op  = ptt_pkg::CELL_FLAGS;
                                    wr_flags = '{valid: 1'b1, armed: 1'b0,
                                                 awaiting: 1'b1};
                                end
                                else
                                begin
                                    cell_op = ptt_pkg::CELL_DELETE;
                                    occ_clr = 1'b1;
                                end
                            end
                        end
                        ptt_pkg::OP_REPLY:
                        begin
                            rsp_next.kind = ptt_pkg::KIND_DONE;
                            if (hit_reg && hit_await_reg)
                            begin
                                rsp_next.ok = 1'b1;
                                out_dec     = 1'b1;
                                if (hit_armed_reg && item_reg.new_interval != '0)
                                begin
                                    // re-arm in place, age rank unchanged
                                    cell_op  = ptt_pkg::CELL_WRITE;
                                    wr_flags = '{valid: 1'b1, armed: 1'b1,
                                                 awaiting: 1'b0};
                                    wr_slot  = SLOT_W'(item_reg.timer_id);
                                end
                                else
                                begin
                                    cell_op = ptt_pkg::CELL_DELETE;
                                    occ_clr = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ptt_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    // head cell goes to the tail, marked if it fires now
                    scan_step           = 1'b1;
                    cell_op             = ptt_pkg::CELL_ROTATE;
                    tail_flags          = cell_flags[0];
                    tail_flags.awaiting = cell_flags[0].awaiting | head_fire;
                    if (head_fire)
                    begin
                        emit                    = 1'b1;
                        out_inc                 = 1'b1;
                        rsp_next.kind           = ptt_pkg::KIND_FIRED;
                        rsp_next.ok             = 1'b1;
                        rsp_next.slot_out       = 4'(cell_slot[0]);
                        rsp_next.fired_interval = cell_period[0];
                        rsp_next.elapsed        = now_reg;
                    end
                end
            end
            ptt_pkg::ST_CLOSE:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    rsp_next.kind    = ptt_pkg::KIND_DONE;
                    rsp_next.ok      = !blocked_reg;
                    rsp_next.elapsed = now_reg;
                    rsp_next.last    = 1'b1;
                    disp_we          = !blocked_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ptt_pkg::ST_IDLE;
            tick_origin_reg <= '0;
            dispatch_reg    <= '0;
            occ_reg         <= '0;
            outstanding_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tick_origin_reg <= cfg_wdata;
            end
            if (disp_we)
            begin
                dispatch_reg <= now_reg;
            end
            if (occ_set)
            begin
                occ_reg[free_reg] <= 1'b1;
            end
            if (occ_clr)
            begin
                occ_reg[SLOT_W'(item_reg.timer_id)] <= 1'b0;
            end
            if (out_inc)
            begin
                outstanding_reg <= outstanding_reg + CNT_W'(1);
            end
            else if (out_dec)
            begin
                outstanding_reg <= outstanding_reg - CNT_W'(1);
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // transaction and lookup registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            now_reg  <= req.raw_time - tick_origin_reg;
        end
        if (state_reg == ptt_pkg::ST_FIND)
        begin
            pos_reg       <= hit_pos;
            hit_reg       <= |hit_vec;
            hit_armed_reg <= hit_armed;
            hit_await_reg <= hit_await;
            free_reg      <= free_slot;
            full_reg      <= &occ_reg;
            blocked_reg   <= (outstanding_reg != '0);
            scan_cnt_reg  <= '0;
        end
        else if (scan_step)
        begin
            scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // chain of cells, cell 0 newest
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        assign cell_ctl[k].op       = cell_op;
        assign cell_ctl[k].at_pos   = (SLOT_W'(k) == pos_reg);
        assign cell_ctl[k].from_pos = (SLOT_W'(k) >= pos_reg);

        if (k == 0)
        begin : g_head
            assign prev_flags[k]    = wr_flags;
            assign prev_slot[k]     = wr_slot;
            assign prev_deadline[k] = wr_deadline;
            assign prev_period[k]   = item_reg.new_interval;
        end
        else
        begin : g_mid_prev
            assign prev_flags[k]    = cell_flags[k-1];
            assign prev_slot[k]     = cell_slot[k-1];
            assign prev_deadline[k] = cell_deadline[k-1];
            assign prev_period[k]   = cell_period[k-1];
        end

        // the tail takes the rotated head, or an empty entry on delete
        if (k == SLOTS - 1)
        begin : g_tail
            assign next_flags[k]    = tail_flags;
            assign next_slot[k]     = cell_slot[0];
            assign next_deadline[k] = cell_deadline[0];
            assign next_period[k]   = cell_period[0];
        end
        else
        begin : g_mid_next
            assign next_flags[k]    = cell_flags[k+1];
            assign next_slot[k]     = cell_slot[k+1];
            assign next_deadline[k] = cell_deadline[k+1];
            assign next_period[k]   = cell_period[k+1];
        end

        ptt_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (cell_ctl[k]),
            .prev_flags    (prev_flags[k]),
            .prev_slot     (prev_slot[k]),
            .prev_deadline (prev_deadline[k]),
            .prev_period   (prev_period[k]),
            .next_flags    (next_flags[k]),
            .next_slot     (next_slot[k]),
            .next_deadline (next_deadline[k]),
            .next_period   (next_period[k]),
            .wr_flags      (wr_flags),
            .wr_slot       (wr_slot),
            .wr_deadline   (wr_deadline),
            .wr_period     (item_reg.new_interval),
            .cur_flags     (cell_flags[k]),
            .cur_slot      (cell_slot[k]),
            .cur_deadline  (cell_deadline[k]),
            .cur_period    (cell_period[k])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ design/ptt_checker.sv @@
// port-level checks of the periodic timer table and their bind
`default_nettype none

`include "periodic_timer_table_macros.svh"

module ptt_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire ptt_pkg::rsp_t rsp
);

    // one transaction at a time: ready drops right after acceptance
    `PTT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // a stalled result holds
    `PTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // a firing is never the final result of its transaction
    `PTT_ASSERT_IMPLIES(a_fired_form, rsp_valid && rsp.kind == ptt_pkg::KIND_FIRED,
        rsp.ok && !rsp.last)

    // every other result closes its transaction and carries no interval
    `PTT_ASSERT_IMPLIES(a_close_form, rsp_valid && rsp.kind != ptt_pkg::KIND_FIRED,
        rsp.last && rsp.fired_interval == '0)

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// testbench of the periodic timer table: directed table, then random traffic against a predictor
module testbench;

    localparam int SLOTS        = ptt_pkg::SLOTS_DEFAULT;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 5;
    // this is several times the slowest run
    localparam int LIMIT_CYCLES = 300000;
    // let a full tick pass after the last result
    localparam int DRAIN_CYCLES = SLOTS + 8;

    // every input of the block starts at a known value
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [31:0]    cfg_wdata = '0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    ptt_pkg::req_t  req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    ptt_pkg::rsp_t  rsp;

    periodic_timer_table #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow copy of the timer table, in its reset state
    logic        slot_armed    [SLOTS] = '{default: 1'b0};
    logic        slot_waiting  [SLOTS] = '{default: 1'b0};
    logic [31:0] slot_deadline [SLOTS] = '{default: '0};
    logic [31:0] slot_period   [SLOTS] = '{default: '0};
    logic [3:0]  slot_rank     [SLOTS] = '{default: '0};
    int          occupied_count        = 0;
    int          replies_due           = 0;
    logic [31:0] dispatch_at           = '0;
    logic [31:0] tick_origin           = '0;

    ptt_pkg::rsp_t pending_results [$];
    ptt_pkg::rsp_t oldest_result;
    int            failures   = 0;
    int            stall_left = 0;
    bit            idle_on    = 1'b1;
    // raw tick count that the random traffic walks forward
    logic [31:0]   wall_ticks = '0;

    typedef struct packed {
        ptt_pkg::req_t req;
        logic          typed;
        ptt_pkg::rsp_t rsp;
    } stim_row_t;

    stim_row_t directed_rows [$];

    function automatic bit slot_busy(int s);
        return slot_armed[s] || slot_waiting[s];
    endfunction

    function automatic ptt_pkg::rsp_t make_rsp(ptt_pkg::kind_t kind, logic ok,
                                               logic [3:0] slot,
                                               logic [31:0] fired_interval,
                                               logic [31:0] elapsed, logic last);
        ptt_pkg::rsp_t r;
        r.kind           = kind;
        r.ok             = ok;
        r.slot_out       = slot;
        r.fired_interval = fired_interval;
        r.elapsed        = elapsed;
        r.last           = last;
        return r;
    endfunction

    // a slot leaves the age ranking: everything older moves up by one
    function automatic void free_slot(int s);
        for (int t = 0; t < SLOTS; t++)
            if (t != s && slot_busy(t) && slot_rank[t] > slot_rank[s])
                slot_rank[t] = slot_rank[t] - 1'b1;
        slot_armed[s]   = 1'b0;
        slot_waiting[s] = 1'b0;
        if (occupied_count > 0)
            occupied_count--;
    endfunction

    // apply one accepted transaction to the shadow table and queue its results
    function automatic void predict_timer_results(ptt_pkg::req_t r);
        logic [31:0] now;
        logic [31:0] lag;
        int          found;
        int          fired;
        int          id;
        now   = r.raw_time - tick_origin;
        id    = r.timer_id;
        found = -1;
        fired = 0;
        case (r.op)
            ptt_pkg::OP_ADD:
            begin
                if (r.new_interval != 0)
                    for (int s = 0; s < SLOTS && found < 0; s++)
                        if (!slot_busy(s))
                            found = s;
                if (found < 0)
                begin
                    // zero interval or table full
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_ADD, 1'b0, '0, '0, now,
                                                       1'b1));
                end
                else
                begin
                    for (int t = 0; t < SLOTS; t++)
                        if (slot_busy(t))
                            slot_rank[t] = slot_rank[t] + 1'b1;
                    slot_rank[found]     = '0;
                    slot_armed[found]    = 1'b1;
                    slot_waiting[found]  = 1'b0;
                    slot_period[found]   = r.new_interval;
                    slot_deadline[found] = now + r.new_interval;
                    occupied_count++;
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_ADD, 1'b1, 4'(found), '0,
                                                       now, 1'b1));
                end
            end
            ptt_pkg::OP_REMOVE:
            begin
                if (!slot_armed[id])
                begin
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_REMOVE, 1'b0, 4'(id), '0,
                                                       '0, 1'b1));
                end
                else
                begin
                    // a slot still owed a reply stays occupied until that reply
                    if (slot_waiting[id])
                        slot_armed[id] = 1'b0;
                    else
                        free_slot(id);
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_REMOVE, 1'b1, 4'(id), '0,
                                                       '0, 1'b1));
                end
            end
            ptt_pkg::OP_REPLY:
            begin
                if (!slot_waiting[id])
                begin
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_DONE, 1'b0, 4'(id), '0,
                                                       '0, 1'b1));
                end
                else
                begin
                    slot_waiting[id] = 1'b0;
                    if (replies_due > 0)
                        replies_due--;
                    if (slot_armed[id] && r.new_interval != 0)
                    begin
                        // reload counts from the time of the tick that fired it
                        slot_period[id]   = r.new_interval;
                        slot_deadline[id] = dispatch_at + r.new_interval;
                    end
                    else
                    begin
                        slot_waiting[id] = 1'b1;
                        free_slot(id);
                    end
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_DONE, 1'b1, 4'(id), '0,
                                                       '0, 1'b1));
                end
            end
            default:
            begin
                if (replies_due > 0)
                begin
                    // nothing fires while replies are owed
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_DONE, 1'b0, '0, '0, now,
                                                       1'b1));
                end
                else
                begin
                    // walk the ranking newest first
                    for (int rank = 0; rank < occupied_count; rank++)
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            lag = now - slot_deadline[s];
                            if (slot_busy(s) && slot_rank[s] == rank && slot_armed[s] &&
                                !slot_waiting[s] && fired < ptt_pkg::MAX_FIRE && !lag[31])
                            begin
                                slot_waiting[s] = 1'b1;
                                replies_due++;
                                pending_results.push_back(make_rsp(ptt_pkg::KIND_FIRED, 1'b1,
                                                                   4'(s), slot_period[s],
                                                                   now, 1'b0));
                                fired++;
                            end
                        end
                    dispatch_at = now;
                    pending_results.push_back(make_rsp(ptt_pkg::KIND_DONE, 1'b1, '0, '0, now,
                                                       1'b1));
                end
            end
        endcase
    endfunction

    function automatic ptt_pkg::req_t make_req(ptt_pkg::op_t op, logic [3:0] id,
                                               logic [31:0] ival, logic [31:0] raw);
        ptt_pkg::req_t r;
        r.op           = op;
        r.timer_id     = id;
        r.new_interval = ival;
        r.raw_time     = raw;
        return r;
    endfunction

    function automatic void add_row(ptt_pkg::op_t op, logic [3:0] id, logic [31:0] ival,
                                    logic [31:0] raw, logic typed, ptt_pkg::rsp_t want);
        stim_row_t row;
        row.req   = make_req(op, id, ival, raw);
        row.typed = typed;
        row.rsp   = want;
        directed_rows.push_back(row);
    endfunction

    // mostly short intervals so timers fire often, with zero and full-range ones mixed in
    function automatic logic [31:0] random_interval();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return '0;
        else if (roll < 90)
            return 32'($urandom_range(1, 60));
        return $urandom;
    endfunction

    // one random transaction shaped by the shadow table: replies answer real firings
    task automatic random_item(output ptt_pkg::req_t r);
        int           roll;
        int           pick [$];
        ptt_pkg::op_t sel;
        roll = $urandom_range(0, 99);
        // unused fields carry random bits too
        r.op           = ptt_pkg::op_t'($urandom_range(0, 3));
        r.timer_id     = 4'($urandom_range(0, SLOTS - 1));
        r.new_interval = $urandom;
        r.raw_time     = $urandom;
        if (replies_due > 0)
            sel = roll < 80 ? ptt_pkg::OP_REPLY
                            : (roll < 90 ? ptt_pkg::OP_TICK : ptt_pkg::OP_REMOVE);
        else
            sel = roll < 35 ? ptt_pkg::OP_ADD
                            : (roll < 50 ? ptt_pkg::OP_REMOVE
                                         : (roll < 88 ? ptt_pkg::OP_TICK : ptt_pkg::OP_REPLY));
        r.op = sel;
        case (sel)
            ptt_pkg::OP_ADD:
            begin
                r.new_interval = random_interval();
                r.raw_time     = wall_ticks;
            end
            ptt_pkg::OP_REMOVE:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_armed[s])
                        pick.push_back(s);
                if (pick.size() > 0 && $urandom_range(0, 4) != 0)
                    r.timer_id = 4'(pick[$urandom_range(0, pick.size() - 1)]);
            end
            ptt_pkg::OP_TICK:
            begin
                // now and then time jumps anywhere, so the wraparound compare gets exercised
                if ($urandom_range(0, 29) == 0)
                    wall_ticks = $urandom;
                else
                    wall_ticks = wall_ticks + 32'($urandom_range(0, 40));
                r.raw_time = wall_ticks;
            end
            default:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_waiting[s])
                        pick.push_back(s);
                if (pick.size() > 0 && $urandom_range(0, 9) != 0)
                    r.timer_id = 4'(pick[$urandom_range(0, pick.size() - 1)]);
                r.new_interval = random_interval();
            end
        endcase
    endtask

    // offer one request transaction; entered and left at a falling edge
    task automatic send_item(ptt_pkg::req_t r, logic typed, ptt_pkg::rsp_t want);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predict_timer_results(r);
        // where the row gives its own answer, that answer stands in for the prediction
        if (typed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge clk);
    endtask

    task automatic run_random(int count);
        ptt_pkg::req_t r;
        repeat (count)
        begin
            random_item(r);
            send_item(r, 1'b0, '0);
        end
    endtask

    // hold off the sender until every result is back, then write the origin
    task automatic drain_and_set_origin(logic [31:0] value);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        tick_origin  = value;
        wall_ticks   = value + 32'($urandom_range(0, 1000));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // response side: random stall bursts, none once idling is switched off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // every result transaction is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d ok %0d slot %0d elapsed %h last %0d",
                         $time, rsp.kind, rsp.ok, rsp.slot_out, rsp.elapsed, rsp.last);
                failures++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.kind !== oldest_result.kind || rsp.ok !== oldest_result.ok ||
                    rsp.slot_out !== oldest_result.slot_out ||
                    rsp.fired_interval !== oldest_result.fired_interval ||
                    rsp.elapsed !== oldest_result.elapsed || rsp.last !== oldest_result.last)
                begin
                    $display("%0t: mismatch, expected kind %0d ok %0d slot %0d interval %h",
                             $time, oldest_result.kind, oldest_result.ok,
                             oldest_result.slot_out, oldest_result.fired_interval,
                             " elapsed %h last %0d, actual kind %0d ok %0d slot %0d",
                             oldest_result.elapsed, oldest_result.last,
                             rsp.kind, rsp.ok, rsp.slot_out,
                             " interval %h elapsed %h last %0d",
                             rsp.fired_interval, rsp.elapsed, rsp.last);
                    failures++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        // directed table, origin zero; typed rows carry an answer that is plain to see
        // tick on an empty table closes with nothing fired
        add_row(ptt_pkg::OP_TICK,   4'd0,  32'd0, 32'd0, 1'b1,
                make_rsp(ptt_pkg::KIND_DONE, 1'b1, 4'd0, '0, 32'd0, 1'b1));
        // add with zero interval fails
        add_row(ptt_pkg::OP_ADD,    4'd0,  32'd0, 32'd5, 1'b1,
                make_rsp(ptt_pkg::KIND_ADD, 1'b0, 4'd0, '0, 32'd5, 1'b1));
        // remove of a slot that is not armed
        add_row(ptt_pkg::OP_REMOVE, 4'd15, 32'd0, 32'd0, 1'b1,
                make_rsp(ptt_pkg::KIND_REMOVE, 1'b0, 4'd15, '0, '0, 1'b1));
        // reply to a slot that never fired
        add_row(ptt_pkg::OP_REPLY,  4'd3,  32'd0, 32'd0, 1'b1,
                make_rsp(ptt_pkg::KIND_DONE, 1'b0, 4'd3, '0, '0, 1'b1));
        // first add takes the lowest slot
        add_row(ptt_pkg::OP_ADD,    4'd0,  32'd10, 32'd0, 1'b1,
                make_rsp(ptt_pkg::KIND_ADD, 1'b1, 4'd0, '0, 32'd0, 1'b1));
        add_row(ptt_pkg::OP_ADD,    4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ptt_pkg::OP_ADD,    4'd0,  32'd1, 32'd3, 1'b0, '0);
        // all three due, fired newest first
        add_row(ptt_pkg::OP_TICK,   4'd0,  32'd0, 32'd10, 1'b0, '0);
        // replies still owed, so nothing fires
        add_row(ptt_pkg::OP_TICK,   4'd0,  32'd0, 32'd11, 1'b1,
                make_rsp(ptt_pkg::KIND_DONE, 1'b0, 4'd0, '0, 32'd11, 1'b1));
        // reload, stop, and remove while a reply is owed
        add_row(ptt_pkg::OP_REPLY,  4'd2,  32'd5, 32'd0, 1'b0, '0);
        add_row(ptt_pkg::OP_REPLY,  4'd1,  32'd0, 32'd0, 1'b0, '0);
        add_row(ptt_pkg::OP_REMOVE, 4'd0,  32'd0, 32'd0, 1'b0, '0);
        add_row(ptt_pkg::OP_REPLY,  4'd0,  32'd7, 32'd0, 1'b0, '0);
        // deadline half the range away sits just outside the wraparound window
        add_row(ptt_pkg::OP_ADD,    4'd0,  32'h8000_0000, 32'd20, 1'b0, '0);
        add_row(ptt_pkg::OP_TICK,   4'd0,  32'd0, 32'd20, 1'b0, '0);
        add_row(ptt_pkg::OP_REMOVE, 4'd2,  32'd0, 32'd0, 1'b0, '0);
        add_row(ptt_pkg::OP_REPLY,  4'd2,  32'd9, 32'd0, 1'b0, '0);
        add_row(ptt_pkg::OP_TICK,   4'd0,  32'd0, 32'h8000_0013, 1'b0, '0);
        add_row(ptt_pkg::OP_TICK,   4'd0,  32'd0, 32'h8000_0014, 1'b0, '0);
        add_row(ptt_pkg::OP_REPLY,  4'd0,  32'h7FFF_FFFF, 32'd0, 1'b0, '0);
        add_row(ptt_pkg::OP_REMOVE, 4'd0,  32'd0, 32'd0, 1'b0, '0);
        // second remove of the same slot fails
        add_row(ptt_pkg::OP_REMOVE, 4'd0,  32'd0, 32'd0, 1'b1,
                make_rsp(ptt_pkg::KIND_REMOVE, 1'b0, 4'd0, '0, '0, 1'b1));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        drain_and_set_origin(32'd0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        // origin at the top of the range: fill the table past full, then fire everything
        drain_and_set_origin(32'hFFFF_FFFF);
        repeat (SLOTS + 1)
            send_item(make_req(ptt_pkg::OP_ADD, 4'($urandom_range(0, SLOTS - 1)),
                               32'($urandom_range(1, 60)), wall_ticks), 1'b0, '0);
        wall_ticks = wall_ticks + 32'd100;
        send_item(make_req(ptt_pkg::OP_TICK, 4'd0, $urandom, wall_ticks), 1'b0, '0);
        run_random(50);

        drain_and_set_origin($urandom);
        run_random(60);

        // last stretch runs without idling on either side
        drain_and_set_origin(32'h8000_0000);
        idle_on    = 1'b0;
        stall_left = 0;
        run_random(50);

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ptt_pkg.sv
design/ptt_cell.sv
design/periodic_timer_table.sv
design/ptt_checker.sv
dv/testbench.sv
